/* hdl/rgbhsv_pkg.sv */
package rgbhsv_pkg;

  // Channel and packing widths.
  localparam int unsigned ChanW  = 8;
  localparam int unsigned TdataW = 3 * ChanW;

  // Restoring divider: one quotient bit per stage.
  localparam int unsigned QuotW  = 8;

  // Hue numerator is degrees * chroma * 17, and the divisor is 24 * chroma,
  // which together scale by 255 / 360.
  localparam int unsigned NumW    = 17;  // degrees * chroma, below 360 * 255
  localparam int unsigned HueRemW = 21;  // NumW value times 17
  localparam int unsigned HueDivW = 20;  // 24 * chroma, pre-shifted by 7
  localparam int unsigned SatRemW = 16;  // 255 * chroma
  localparam int unsigned SatDivW = 15;  // max, pre-shifted by 7

  // Which channel holds the maximum (blue wins ties over green over red).
  typedef enum logic [1:0] {
    SEC_RED   = 2'd0,
    SEC_GREEN = 2'd1,
    SEC_BLUE  = 2'd2
  } sector_e;

  // Payload carried through the divider stages.
  typedef struct packed {
    logic [HueRemW-1:0] hue_rem;
    logic [HueDivW-1:0] hue_div;
    logic [QuotW-1:0]   hue_q;
    logic [SatRemW-1:0] sat_rem;
    logic [SatDivW-1:0] sat_div;
    logic [QuotW-1:0]   sat_q;
    logic               hue_zero;
    logic               sat_zero;
    logic [ChanW-1:0]   val;
  } div_t;

endpackage

/* hdl/rgbhsv_div_stage.sv */
module rgbhsv_div_stage
  import rgbhsv_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic valid_i,
  output logic ready_o,
  input  div_t data_i,
  output logic valid_o,
  input  logic ready_i,
  output div_t data_o
);

  logic valid_q;
  div_t data_q;
  div_t data_d;
  logic hue_ge;
  logic sat_ge;

  // A stage takes a new beat when it is empty or its beat moves on.
  assign ready_o = !valid_q || ready_i;

  // One restoring step for each quotient: compare, subtract, shift divisor.
  always_comb begin
    data_d = data_i;
    hue_ge = data_i.hue_rem >= {1'b0, data_i.hue_div};
    sat_ge = data_i.sat_rem >= {1'b0, data_i.sat_div};
    if (hue_ge) begin
      data_d.hue_rem = data_i.hue_rem - {1'b0, data_i.hue_div};
    end
    if (sat_ge) begin
      data_d.sat_rem = data_i.sat_rem - {1'b0, data_i.sat_div};
    end
    data_d.hue_q   = {data_i.hue_q[QuotW-2:0], hue_ge};
    data_d.sat_q   = {data_i.sat_q[QuotW-2:0], sat_ge};
    data_d.hue_div = data_i.hue_div >> 1;
    data_d.sat_div = data_i.sat_div >> 1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

/* hdl/rgb_to_hsv_pixel.sv */
// RGB to HSV pixel converter, 8 bits per channel.
// Input beats arrive on the s_axis group: tdata holds red, green and blue.
// Output beats leave on the m_axis group: tdata holds hue, saturation and
// value. Value is the largest channel, saturation is 255 * chroma / max and
// hue maps 360 degrees to 255; gray pixels get hue 0, black pixels get
// saturation 0.
// Every stage holds a valid bit and takes a beat when it is empty or its
// beat moves on, so the block accepts one pixel per clock cycle while the
// receiver keeps up, and bubbles close up while the receiver stalls.
// From accept to output valid a beat passes one stage for the max/min and
// sector, one for the degree numerator, one to set up the dividers and
// eight restoring divider stages, one quotient bit each, with hue and
// saturation divided side by side. The last divider stage is the output
// register.
// When the receiver holds m_axis_tready low, beats stay in place and
// nothing is lost or repeated; s_axis_tready drops only once every stage
// is full.
// Reset clears all valid bits; the pipeline is empty afterward and
// s_axis_tready is high.
module rgb_to_hsv_pixel
  import rgbhsv_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [TdataW-1:0] s_axis_tdata,   // red [7:0], green [15:8], blue [23:16]
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [TdataW-1:0] m_axis_tdata    // hue_out [7:0], sat_out [15:8], val_out [23:16]
);

  logic [ChanW-1:0] red;
  logic [ChanW-1:0] green;
  logic [ChanW-1:0] blue;

  assign red   = s_axis_tdata[ChanW-1:0];
  assign green = s_axis_tdata[2*ChanW-1:ChanW];
  assign blue  = s_axis_tdata[3*ChanW-1:2*ChanW];

  // Stage 1: max, min, sector and signed channel difference.
  logic              v1_q;
  logic              rdy1;
  logic [ChanW-1:0]  mx1_q;
  logic [ChanW-1:0]  c1_q;
  sector_e           sec1_q;
  logic signed [8:0] diff1_q;
  logic [ChanW-1:0]  mx1_d;
  logic [ChanW-1:0]  mn1_d;
  sector_e           sec1_d;
  logic signed [8:0] diff1_d;

  // Stage 2: numerator in degrees times chroma.
  logic              v2_q;
  logic              rdy2;
  logic [ChanW-1:0]  mx2_q;
  logic [ChanW-1:0]  c2_q;
  logic [NumW-1:0]   num2_q;
  logic [15:0]       base_c;
  logic signed [17:0] diff_ext;
  logic signed [17:0] diff60;
  logic signed [17:0] num_s;
  logic signed [17:0] c360;
  logic signed [17:0] num_fix;

  // Stage 3: divider setup.
  logic              v3_q;
  logic              rdy3;
  div_t              d3_q;
  div_t              d3_d;

  always_comb begin
    mx1_d = red;
    if (green > mx1_d) begin
      mx1_d = green;
    end
    if (blue > mx1_d) begin
      mx1_d = blue;
    end
    mn1_d = red;
    if (green < mn1_d) begin
      mn1_d = green;
    end
    if (blue < mn1_d) begin
      mn1_d = blue;
    end
    // Blue wins ties over green, green over red.
    if (blue == mx1_d) begin
      sec1_d  = SEC_BLUE;
      diff1_d = $signed({1'b0, red}) - $signed({1'b0, green});
    end else if (green == mx1_d) begin
      sec1_d  = SEC_GREEN;
      diff1_d = $signed({1'b0, blue}) - $signed({1'b0, red});
    end else begin
      sec1_d  = SEC_RED;
      diff1_d = $signed({1'b0, green}) - $signed({1'b0, blue});
    end
  end

  assign rdy1          = !v1_q || rdy2;
  assign s_axis_tready = rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (rdy1) begin
      v1_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && s_axis_tvalid) begin
      mx1_q   <= mx1_d;
      c1_q    <= mx1_d - mn1_d;
      sec1_q  <= sec1_d;
      diff1_q <= diff1_d;
    end
  end

  // Sector base times chroma plus 60 times the difference, wrapped positive.
  always_comb begin
    case (sec1_q)
      SEC_GREEN: base_c = 16'(c1_q) * 16'd120;
      SEC_BLUE:  base_c = 16'(c1_q) * 16'd240;
      default:   base_c = '0;
    endcase
    diff_ext = {{9{diff1_q[8]}}, diff1_q};
    diff60   = diff_ext * 18'sd60;
    num_s    = $signed({2'b00, base_c}) + diff60;
    c360     = $signed(18'(c1_q) * 18'd360);
    num_fix  = (num_s < 0) ? (num_s + c360) : num_s;
    if (num_fix < 0) begin
      num_fix = '0;
    end
  end

  assign rdy2 = !v2_q || rdy3;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (rdy2) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy2 && v1_q) begin
      mx2_q  <= mx1_q;
      c2_q   <= c1_q;
      num2_q <= num_fix[NumW-1:0];
    end
  end

  // Dividend and pre-shifted divisor for both quotients.
  always_comb begin
    d3_d.hue_rem  = HueRemW'(num2_q) * 21'd17;
    d3_d.hue_div  = {13'(c2_q) * 13'd24, 7'b0};
    d3_d.hue_q    = '0;
    d3_d.sat_rem  = SatRemW'(c2_q) * 16'd255;
    d3_d.sat_div  = {mx2_q, 7'b0};
    d3_d.sat_q    = '0;
    d3_d.hue_zero = (c2_q == '0);
    d3_d.sat_zero = (mx2_q == '0);
    d3_d.val      = mx2_q;
  end

  logic [QuotW:0] dv;
  logic [QuotW:0] dr;
  div_t           dd [QuotW+1];

  assign rdy3 = !v3_q || dr[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (rdy3) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy3 && v2_q) begin
      d3_q <= d3_d;
    end
  end

  assign dv[0] = v3_q;
  assign dd[0] = d3_q;

  // Eight divider stages, one quotient bit each.
  for (genvar k = 0; k < QuotW; k++) begin : g_div
    rgbhsv_div_stage u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (dv[k]),
      .ready_o (dr[k]),
      .data_i  (dd[k]),
      .valid_o (dv[k+1]),
      .ready_i (dr[k+1]),
      .data_o  (dd[k+1])
    );
  end

  assign dr[QuotW] = m_axis_tready;

  // Output beat; gray and black pixels force zero quotients.
  assign m_axis_tvalid = dv[QuotW];
  assign m_axis_tdata  = {dd[QuotW].val,
                          dd[QuotW].sat_zero ? {QuotW{1'b0}} : dd[QuotW].sat_q,
                          dd[QuotW].hue_zero ? {QuotW{1'b0}} : dd[QuotW].hue_q};

endmodule
